// File: design/mmsn_pkg.sv
package mmsn_pkg;

  // Action codes carried by an input word.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // Status codes carried by a result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Fraction bits of the Q1.16 result and the full result width.
  localparam int unsigned Q_BITS = 16;
  localparam int unsigned NORM_W = Q_BITS + 1;
  // Width of the divider step counter, one quotient bit per step.
  localparam int unsigned STEP_W = $clog2(Q_BITS);
  // The value 1.0 in Q1.16.
  localparam logic [NORM_W-1:0] Q_ONE = NORM_W'(1) << Q_BITS;

endpackage

// File: design/min_max_sample_normalizer_unit.sv
// Min-max sample normalizer. The block keeps up to DEPTH signed samples in a
// single-port-write, registered-read memory and tracks their running minimum
// and maximum. An input word with action load appends its sample (a load into
// a full store is dropped and reports status full), action read returns the
// stored sample at the given index scaled to (x - min) / (max - min) as an
// unsigned Q1.16 value truncated toward zero, and action clear empties the
// store and restores the minimum to the largest positive value and the
// maximum to the most negative value. A read of an empty store reports status
// empty and a read at or past the count reports status range; when the
// minimum equals the maximum a read returns zero. Every input word produces
// exactly one result word, which also reports the minimum, maximum and count
// after that word. The block works on one word at a time: load, clear, the
// unused action code and all error cases go straight to the hand-off into
// the output register. A read that needs the divider passes through the
// registered memory read, a restoring divider that produces one quotient
// bit per cycle, and the hand-off into the output register; a read of a
// flat range or of a sample at the minimum or maximum skips the divider. A
// finished result waits in the output register while the block is already
// free to accept the next word; the next result then waits internally
// until the output register has been taken. The input is stalled while
// reset is asserted.
module min_max_sample_normalizer_unit #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic [$clog2(DEPTH)-1:0]        index,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [mmsn_pkg::NORM_W-1:0]     normalized,
  output logic signed [SAMPLE_BITS-1:0]   min_value,
  output logic signed [SAMPLE_BITS-1:0]   max_value,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SB    = SAMPLE_BITS;

  // Reset values of the running extremes.
  localparam logic signed [SB-1:0] SAMPLE_TOP    = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_BOTTOM = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  // Sample memory and its registered read port.
  logic signed [SB-1:0] store [DEPTH];
  logic signed [SB-1:0] rd_data;

  // Running state of the store.
  logic [CNT_W-1:0]     sample_count;
  logic signed [SB-1:0] running_min;
  logic signed [SB-1:0] running_max;

  // Divider datapath: the partial remainder stays below the span.
  logic [SB-1:0]                     rem;
  logic [SB-1:0]                     span;
  logic [mmsn_pkg::Q_BITS-1:0]       quo;
  logic [mmsn_pkg::STEP_W-1:0]       step;

  // Result waiting to move into the output register.
  mmsn_pkg::status_t                 res_status;
  logic [mmsn_pkg::NORM_W-1:0]       res_norm;

  logic accept;
  logic store_full;
  logic is_load;
  logic is_read;
  logic is_clear;
  logic idx_ok;
  logic do_write;
  logic do_read;
  logic out_free;

  // Divider step.
  logic [SB:0]          rem_shift;
  logic                 quo_bit;
  logic [SB-1:0]        rem_next;

  // Operands of the setup step after the memory read.
  logic signed [SB:0]   off_wide;
  logic signed [SB:0]   span_wide;

  assign in_stall   = rst || (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign store_full = (sample_count == CNT_W'(DEPTH));
  assign is_load    = (action == mmsn_pkg::ACT_LOAD);
  assign is_read    = (action == mmsn_pkg::ACT_READ);
  assign is_clear   = (action == mmsn_pkg::ACT_CLEAR);
  assign idx_ok     = (CNT_W'(index) < sample_count);
  assign do_write   = accept && is_load && !store_full;
  assign do_read    = accept && is_read && idx_ok;
  assign out_free   = !out_valid || !out_stall;

  assign rem_shift = {rem, 1'b0};
  assign quo_bit   = (rem_shift >= {1'b0, span});
  assign rem_next  = quo_bit ? SB'(rem_shift - {1'b0, span}) : rem_shift[SB-1:0];

  assign off_wide  = SB'(0) + ($signed({rd_data[SB-1], rd_data})
                               - $signed({running_min[SB-1], running_min}));
  assign span_wide = $signed({running_max[SB-1], running_max})
                     - $signed({running_min[SB-1], running_min});

  // Memory: one write at the fill position, one registered read.
  always_ff @(posedge clk) begin
    if (do_write) begin
      store[sample_count[IDX_W-1:0]] <= sample;
    end
    if (do_read) begin
      rd_data <= store[index];
    end
  end

  // Control, running state and divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      running_min  <= SAMPLE_TOP;
      running_max  <= SAMPLE_BOTTOM;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_norm   <= '0;
            res_status <= mmsn_pkg::ST_OK;
            state      <= S_FIN;
            if (is_load) begin
              if (store_full) begin
                res_status <= mmsn_pkg::ST_FULL;
              end else begin
                sample_count <= sample_count + CNT_W'(1);
                if (sample < running_min) begin
                  running_min <= sample;
                end
                if (sample > running_max) begin
                  running_max <= sample;
                end
              end
            end else if (is_read) begin
              if (sample_count == '0) begin
                res_status <= mmsn_pkg::ST_EMPTY;
              end else if (!idx_ok) begin
                res_status <= mmsn_pkg::ST_RANGE;
              end else begin
                state <= S_READ;
              end
            end else if (is_clear) begin
              sample_count <= '0;
              running_min  <= SAMPLE_TOP;
              running_max  <= SAMPLE_BOTTOM;
            end
          end
        end
        S_READ: begin
          // Stored samples always lie between the extremes, so only the
          // flat range and the sample at the maximum need special handling.
          step <= '0;
          quo  <= '0;
          rem  <= off_wide[SB-1:0];
          span <= span_wide[SB-1:0];
          if (running_max <= running_min) begin
            state <= S_FIN;
          end else if (rd_data >= running_max) begin
            res_norm <= mmsn_pkg::Q_ONE;
            state    <= S_FIN;
          end else if (rd_data <= running_min) begin
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          quo  <= {quo[mmsn_pkg::Q_BITS-2:0], quo_bit};
          step <= step + mmsn_pkg::STEP_W'(1);
          if (step == mmsn_pkg::STEP_W'(mmsn_pkg::Q_BITS - 1)) begin
            res_norm <= {1'b0, quo[mmsn_pkg::Q_BITS-2:0], quo_bit};
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      status     <= res_status;
      normalized <= res_norm;
      min_value  <= running_min;
      max_value  <= running_max;
      count      <= sample_count;
    end
  end

  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst) sample_count <= CNT_W'(DEPTH))
    else $error("sample count exceeds depth");

  // A non-empty store has its minimum at or below its maximum.
  assert property (@(posedge clk) disable iff (rst)
    (sample_count != '0) |-> (running_min <= running_max))
    else $error("running extremes out of order");

  // A delivered result never exceeds 1.0 in Q1.16.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normalized <= mmsn_pkg::Q_ONE))
    else $error("normalized result above one");

  // An empty-store status only comes with an empty store.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mmsn_pkg::ST_EMPTY) |-> (count == '0))
    else $error("empty status with samples held");

  // The divider only runs on a nonzero span larger than the remainder.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (span != '0 && rem < span))
    else $error("divider operands out of range");

endmodule
